// ===== sv/first_fit_allocator_compaction_macros.svh =====
// Assertion macros for the first-fit allocator
`ifndef FIRST_FIT_ALLOCATOR_COMPACTION_MACROS_SVH
`define FIRST_FIT_ALLOCATOR_COMPACTION_MACROS_SVH

// check cons in the cycle after ante, outside reset
`define FFAC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ffac assertion failed");

// check cons in the same cycle as ante, outside reset
`define FFAC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ffac assertion failed");

// check cons in the cycle after ante, reset included
`define FFAC_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ffac assertion failed");

`endif

// ===== sv/ffac_pkg.sv =====
// Shared types, constants and functions of the first-fit allocator
`default_nettype none
package ffac_pkg;
  localparam int MEM_UNITS = 256;
  localparam int IDX_W     = $clog2(MEM_UNITS);
  localparam int CNT_W     = $clog2(MEM_UNITS + 1);
  localparam int SIZE_W    = 9;
  localparam int POS_W     = SIZE_W + 1;
  localparam int SUM_W     = SIZE_W + 2;
  localparam int HANDLE_W  = 32;
  localparam int OP_W      = 2;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_ERASE  = 2'd1;
  localparam logic [OP_W-1:0] OP_DEFRAG = 2'd2;

  localparam logic REG_MEM_SIZE = 1'b0;
  localparam logic [SIZE_W-1:0] MEM_SIZE_RST = SIZE_W'(256);

  typedef enum logic [1:0] {CMD_ALLOC, CMD_ERASE, CMD_DEFRAG, CMD_FAIL} cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [SIZE_W-1:0]     size;
    logic [HANDLE_W-1:0]   handle;
  } cmd_t;

  typedef struct packed {
    logic [SIZE_W-1:0]   start;
    logic [SIZE_W-1:0]   len;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } ram_wr_t;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] m);
    logic [SIZE_W-1:0] cap;
    cap = SIZE_W'(MEM_UNITS);
    return (m > cap) ? cap : m;
  endfunction
endpackage
`default_nettype wire

// ===== sv/ffac_if.sv =====
// Item channel interfaces of the first-fit allocator
`default_nettype none
interface ffac_in_if;
  logic                          valid;
  logic                          ready;
  logic [ffac_pkg::OP_W-1:0]     op;
  logic [ffac_pkg::SIZE_W-1:0]   alloc_size;
  logic [ffac_pkg::HANDLE_W-1:0] handle_in;
  modport source (output valid, op, alloc_size, handle_in, input ready);
  modport sink (input valid, op, alloc_size, handle_in, output ready);
endinterface

interface ffac_out_if;
  logic                          valid;
  logic                          ready;
  logic [ffac_pkg::HANDLE_W-1:0] handle_out;
  logic                          ok;
  modport source (output valid, handle_out, ok, input ready);
  modport sink (input valid, handle_out, ok, output ready);
endinterface
`default_nettype wire

// ===== sv/ffac_ram.sv =====
// Generic simple dual-port RAM with registered read
`default_nettype none
module ffac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== sv/ffac_front.sv =====
// Front end: accept items, classify them, queue commands
`default_nettype none
module ffac_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  ffac_in_if.sink                            in_ch,
  input  wire logic [ffac_pkg::SIZE_W-1:0]   eff_size_i,
  output ffac_pkg::cmd_t                     cmd_o,
  output logic                               cmd_valid_o,
  input  wire logic                          cmd_pop_i
);
  import ffac_pkg::*;

  cmd_t       q_r [2];
  logic       head_r, head_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop, tail;
  cmd_t       cls;

  always_comb begin
    cls.size   = in_ch.alloc_size;
    cls.handle = in_ch.handle_in;
    case (in_ch.op)
      OP_ALLOC: begin
        if (in_ch.alloc_size == '0 || in_ch.alloc_size > eff_size_i) begin
          cls.kind = CMD_FAIL;
        end else begin
          cls.kind = CMD_ALLOC;
        end
      end
      OP_ERASE:  cls.kind = CMD_ERASE;
      OP_DEFRAG: cls.kind = CMD_DEFRAG;
      default:   cls.kind = CMD_FAIL;
    endcase
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid_o = (cnt_r != 2'd0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign tail        = head_r ^ cnt_r[0];
  assign cmd_o       = q_r[head_r];

  always_comb begin
    head_nxt = pop ? ~head_r : head_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (push) begin
      q_r[tail] <= cls;
    end
  end
endmodule
`default_nettype wire

// ===== sv/ffac_back.sv =====
// Back end: run commands against the block table, hold the result
`default_nettype none
module ffac_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ffac_pkg::cmd_t                cmd_i,
  input  wire logic                          cmd_valid_i,
  output logic                               cmd_pop_o,
  input  wire logic [ffac_pkg::SIZE_W-1:0]   eff_size_i,
  output ffac_pkg::ram_wr_t                  ram_wr_o,
  output logic [ffac_pkg::IDX_W-1:0]         ram_raddr_o,
  input  wire ffac_pkg::entry_t              ram_rdata_i,
  ffac_out_if.source                         out_ch
);
  import ffac_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_ASCAN, S_SHUP, S_INS, S_ESCAN, S_SHDN, S_DEFRAG
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [HANDLE_W-1:0] hc_r, hc_nxt, hc_new;
  logic                rd_on_r, rd_on_nxt, rd_up_r, rd_up_nxt;
  logic [IDX_W-1:0]    rd_i_r, rd_i_nxt, rd_end_r, rd_end_nxt;
  logic                dv_r, dv_nxt;
  logic [IDX_W-1:0]    wi_r, wi_nxt, p_r, p_nxt;
  logic [POS_W-1:0]    lo_r, lo_nxt;
  cmd_t                cur_r, cur_nxt;
  logic                res_valid_r, res_valid_nxt, res_ok_r, res_ok_nxt;
  logic [HANDLE_W-1:0] res_handle_r, res_handle_nxt;
  entry_t              ent;
  logic [IDX_W-1:0]    n_m1;
  logic                last;
  logic [POS_W-1:0]    eff1, ent_end;
  logic [SUM_W-1:0]    fit_sum, tail_sum;

  assign ent      = ram_rdata_i;
  assign n_m1     = IDX_W'(cnt_r - 1'b1);
  assign last     = (wi_r == n_m1);
  assign eff1     = POS_W'(eff_size_i) + 1'b1;
  assign ent_end  = POS_W'(ent.start) + POS_W'(ent.len);
  assign fit_sum  = SUM_W'(lo_r) + SUM_W'(cur_r.size);
  assign tail_sum = SUM_W'(ent_end) + SUM_W'(cur_r.size);
  assign hc_new   = (hc_r + 1'b1 == '0) ? HANDLE_W'(1) : hc_r + 1'b1;

  assign out_ch.valid      = res_valid_r;
  assign out_ch.handle_out = res_handle_r;
  assign out_ch.ok         = res_ok_r;
  assign ram_raddr_o       = rd_i_r;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    hc_nxt         = hc_r;
    rd_on_nxt      = rd_on_r;
    rd_up_nxt      = rd_up_r;
    rd_i_nxt       = rd_i_r;
    rd_end_nxt     = rd_end_r;
    dv_nxt         = 1'b0;
    wi_nxt         = wi_r;
    p_nxt          = p_r;
    lo_nxt         = lo_r;
    cur_nxt        = cur_r;
    res_valid_nxt  = res_valid_r;
    res_ok_nxt     = res_ok_r;
    res_handle_nxt = res_handle_r;
    cmd_pop_o      = 1'b0;
    ram_wr_o.we    = 1'b0;
    ram_wr_o.addr  = wi_r;
    ram_wr_o.data  = ent;

    // advance the read stream
    if (rd_on_r) begin
      dv_nxt = 1'b1;
      wi_nxt = rd_i_r;
      if (rd_i_r == rd_end_r) begin
        rd_on_nxt = 1'b0;
      end else begin
        rd_i_nxt = rd_up_r ? rd_i_r + 1'b1 : rd_i_r - 1'b1;
      end
    end

    if (out_ch.valid && out_ch.ready) begin
      res_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        rd_on_nxt = 1'b0;
        dv_nxt    = 1'b0;
        if (cmd_valid_i && !res_valid_r) begin
          cmd_pop_o      = 1'b1;
          cur_nxt        = cmd_i;
          lo_nxt         = POS_W'(1);
          res_handle_nxt = '0;
          res_ok_nxt     = 1'b0;
          rd_up_nxt      = 1'b1;
          rd_i_nxt       = '0;
          rd_end_nxt     = n_m1;
          case (cmd_i.kind)
            CMD_ALLOC: begin
              if (cnt_r == CNT_W'(MEM_UNITS)) begin
                res_valid_nxt = 1'b1;
              end else if (cnt_r == '0) begin
                p_nxt     = '0;
                state_nxt = S_INS;
              end else begin
                rd_on_nxt = 1'b1;
                state_nxt = S_ASCAN;
              end
            end
            CMD_ERASE: begin
              if (cnt_r == '0) begin
                res_valid_nxt = 1'b1;
              end else begin
                rd_on_nxt = 1'b1;
                state_nxt = S_ESCAN;
              end
            end
            CMD_DEFRAG: begin
              if (cnt_r == '0) begin
                res_ok_nxt    = 1'b1;
                res_valid_nxt = 1'b1;
              end else begin
                rd_on_nxt = 1'b1;
                state_nxt = S_DEFRAG;
              end
            end
            default: begin
              res_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      S_ASCAN: begin
        if (dv_r) begin
          if (fit_sum <= SUM_W'(ent.start) && fit_sum <= SUM_W'(eff1)) begin
            p_nxt      = wi_r;
            dv_nxt     = 1'b0;
            rd_on_nxt  = 1'b1;
            rd_up_nxt  = 1'b0;
            rd_i_nxt   = n_m1;
            rd_end_nxt = wi_r;
            state_nxt  = S_SHUP;
          end else begin
            lo_nxt = ent_end;
            if (last) begin
              if (tail_sum <= SUM_W'(eff1)) begin
                p_nxt     = IDX_W'(cnt_r);
                state_nxt = S_INS;
              end else begin
                res_valid_nxt = 1'b1;
                state_nxt     = S_IDLE;
              end
            end
          end
        end
      end

      S_SHUP: begin
        if (dv_r) begin
          ram_wr_o.we   = 1'b1;
          ram_wr_o.addr = wi_r + 1'b1;
          if (wi_r == p_r) begin
            state_nxt = S_INS;
          end
        end
      end

      S_INS: begin
        ram_wr_o.we          = 1'b1;
        ram_wr_o.addr        = p_r;
        ram_wr_o.data.start  = SIZE_W'(lo_r);
        ram_wr_o.data.len    = cur_r.size;
        ram_wr_o.data.handle = hc_new;
        hc_nxt               = hc_new;
        cnt_nxt              = cnt_r + 1'b1;
        res_handle_nxt       = hc_new;
        res_ok_nxt           = 1'b1;
        res_valid_nxt        = 1'b1;
        state_nxt            = S_IDLE;
      end

      S_ESCAN: begin
        if (dv_r) begin
          if (ent.handle == cur_r.handle) begin
            p_nxt  = wi_r;
            dv_nxt = 1'b0;
            if (last) begin
              cnt_nxt       = cnt_r - 1'b1;
              res_ok_nxt    = 1'b1;
              res_valid_nxt = 1'b1;
              rd_on_nxt     = 1'b0;
              state_nxt     = S_IDLE;
            end else begin
              rd_on_nxt  = 1'b1;
              rd_up_nxt  = 1'b1;
              rd_i_nxt   = wi_r + 1'b1;
              rd_end_nxt = n_m1;
              state_nxt  = S_SHDN;
            end
          end else if (last) begin
            res_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end

      S_SHDN: begin
        if (dv_r) begin
          ram_wr_o.we   = 1'b1;
          ram_wr_o.addr = wi_r - 1'b1;
          if (last) begin
            cnt_nxt       = cnt_r - 1'b1;
            res_ok_nxt    = 1'b1;
            res_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end

      S_DEFRAG: begin
        if (dv_r) begin
          ram_wr_o.we         = 1'b1;
          ram_wr_o.data.start = SIZE_W'(lo_r);
          lo_nxt              = lo_r + POS_W'(ent.len);
          if (last) begin
            res_ok_nxt    = 1'b1;
            res_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      hc_r        <= '0;
      rd_on_r     <= 1'b0;
      dv_r        <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      hc_r        <= hc_nxt;
      rd_on_r     <= rd_on_nxt;
      dv_r        <= dv_nxt;
      res_valid_r <= res_valid_nxt;
    end
    rd_up_r      <= rd_up_nxt;
    rd_i_r       <= rd_i_nxt;
    rd_end_r     <= rd_end_nxt;
    wi_r         <= wi_nxt;
    p_r          <= p_nxt;
    lo_r         <= lo_nxt;
    cur_r        <= cur_nxt;
    res_ok_r     <= res_ok_nxt;
    res_handle_r <= res_handle_nxt;
  end
endmodule
`default_nettype wire

// ===== sv/first_fit_allocator_compaction.sv =====
// Top level of the first-fit allocator with compaction
//
//   port     dir  handshake           payload
//   in_ch    in   valid/ready         op, alloc_size, handle_in
//   out_ch   out  valid/ready         handle_out, ok
//   cfg_*    in   APB write/read      mem_size at byte address 0
//
// Command pop to result: allocate scans, then inserts at the tail (at once if
// empty) or shifts and inserts into a gap; erase scans, then shifts down unless
// it is last; defragment packs all blocks. Table RAM: one read, one write per cycle.
// Reset clears the block count and handle counter; no clearing pass.
// A two-entry command queue takes items while the back end works or
// while a result waits on out_ch, and registers each item between accept and pop.
`default_nettype none
module first_fit_allocator_compaction (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  ffac_in_if.sink                            in_ch,
  ffac_out_if.source                         out_ch,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [ffac_pkg::CFG_AW-1:0]   cfg_paddr,
  input  wire logic [ffac_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic      [ffac_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                               cfg_pready
);
  import ffac_pkg::*;

  logic [SIZE_W-1:0] mem_size_r, mem_size_nxt;
  logic [SIZE_W-1:0] eff;
  cmd_t              cmd;
  logic              cmd_valid, cmd_pop;
  ram_wr_t           ram_wr;
  logic [IDX_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_q;

  assign cfg_pready = 1'b1;
  assign eff        = eff_size(mem_size_r);
  assign cfg_prdata = (cfg_paddr[2] == REG_MEM_SIZE) ? CFG_DW'(mem_size_r) : '0;

  always_comb begin
    mem_size_nxt = mem_size_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_MEM_SIZE) begin
      mem_size_nxt = cfg_pwdata[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_size_r <= MEM_SIZE_RST;
    end else begin
      mem_size_r <= mem_size_nxt;
    end
  end

  ffac_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .eff_size_i  (eff),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  ffac_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .eff_size_i  (eff),
    .ram_wr_o    (ram_wr),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (entry_t'(ram_q)),
    .out_ch      (out_ch)
  );

  ffac_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MEM_UNITS)
  ) u_table (
    .clk   (clk),
    .we    (ram_wr.we),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );
endmodule
`default_nettype wire

// ===== sv/ffac_checker.sv =====
// Port-level checker of the first-fit allocator and its bind
`default_nettype none
`include "first_fit_allocator_compaction_macros.svh"
module ffac_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [ffac_pkg::HANDLE_W-1:0] out_handle,
  input wire logic                          out_ok
);
  `FFAC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `FFAC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_handle))
  `FFAC_ASSERT_SAME(a_fail_null, out_valid && !out_ok, out_handle == '0)
  `FFAC_ASSERT_ALWAYS(a_rst_idle, !rst_n, !out_valid)
endmodule

bind first_fit_allocator_compaction ffac_checker u_ffac_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_handle (out_ch.handle_out),
  .out_ok     (out_ch.ok)
);
`default_nettype wire

// ===== tb/sv/first_fit_allocator_compaction_checker.sv =====
// Checker of the first-fit allocator: predicts results and compares them
`timescale 1ns / 100ps
module first_fit_allocator_compaction_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [ffac_pkg::OP_W-1:0]     in_op,
  input  logic [ffac_pkg::SIZE_W-1:0]   in_alloc_size,
  input  logic [ffac_pkg::HANDLE_W-1:0] in_handle,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [ffac_pkg::HANDLE_W-1:0] out_handle,
  input  logic                          out_ok,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic                          cfg_pready,
  input  logic [ffac_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [ffac_pkg::CFG_DW-1:0]   cfg_pwdata,
  output int                            pending,
  output int                            errors
);
  import ffac_pkg::*;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic                ok;
  } alloc_result_t;

  int unsigned         blk_pos [MEM_UNITS];
  int unsigned         blk_units [MEM_UNITS];
  logic [HANDLE_W-1:0] blk_id [MEM_UNITS];
  int unsigned         live_blocks;
  logic [HANDLE_W-1:0] next_handle;
  logic [SIZE_W-1:0]   mem_units_reg;
  alloc_result_t       awaited_results[$];

  function automatic alloc_result_t place_block(int unsigned units);
    alloc_result_t r;
    int unsigned cap, lo, hi, n;
    r = '0;
    cap = (mem_units_reg > MEM_UNITS) ? MEM_UNITS : mem_units_reg;
    n = live_blocks;
    if (units == 0 || units > cap || n >= MEM_UNITS) return r;
    for (int i = 0; i <= n; i++) begin
      lo = (i == 0) ? 1 : blk_pos[i-1] + blk_units[i-1];
      hi = (i < n) ? blk_pos[i] : cap + 1;
      if (lo + units <= hi && lo + units <= cap + 1) begin
        for (int j = n; j > i; j--) begin
          blk_pos[j] = blk_pos[j-1];
          blk_units[j] = blk_units[j-1];
          blk_id[j] = blk_id[j-1];
        end
        next_handle = next_handle + 1;
        if (next_handle == 0) next_handle = 1;
        blk_pos[i] = lo;
        blk_units[i] = units;
        blk_id[i] = next_handle;
        live_blocks = n + 1;
        r.handle = next_handle;
        r.ok = 1'b1;
        return r;
      end
    end
    return r;
  endfunction

  function automatic logic free_block(logic [HANDLE_W-1:0] h);
    for (int i = 0; i < live_blocks; i++) begin
      if (blk_id[i] == h) begin
        for (int j = i; j + 1 < live_blocks; j++) begin
          blk_pos[j] = blk_pos[j+1];
          blk_units[j] = blk_units[j+1];
          blk_id[j] = blk_id[j+1];
        end
        live_blocks--;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void pack_blocks();
    int unsigned pos;
    pos = 1;
    for (int i = 0; i < live_blocks; i++) begin
      blk_pos[i] = pos;
      pos += blk_units[i];
    end
  endfunction

  function automatic alloc_result_t predict_op(logic [OP_W-1:0] op, logic [SIZE_W-1:0] sz,
                                               logic [HANDLE_W-1:0] h);
    alloc_result_t r;
    r = '0;
    case (op)
      OP_ALLOC: r = place_block(sz);
      OP_ERASE: r.ok = free_block(h);
      OP_DEFRAG: begin
        pack_blocks();
        r.ok = 1'b1;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_result_t exp_r;
    alloc_result_t pred_r;
    if (!rst_n) begin
      live_blocks = 0;
      next_handle = '0;
      mem_units_reg = MEM_SIZE_RST;
      awaited_results.delete();
      errors = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[2] == REG_MEM_SIZE)
        mem_units_reg = cfg_pwdata[SIZE_W-1:0];
      if (in_valid && in_ready) begin
        pred_r = predict_op(in_op, in_alloc_size, in_handle);
        awaited_results.insert(awaited_results.size(), pred_r);
      end
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected item handle_out=%h ok=%b", $time, out_handle, out_ok);
          errors++;
        end else begin
          exp_r = awaited_results.pop_front();
          if (out_handle !== exp_r.handle) begin
            $display("%0t: handle_out expected %h actual %h", $time, exp_r.handle, out_handle);
            errors++;
          end
          if (out_ok !== exp_r.ok) begin
            $display("%0t: ok expected %b actual %b", $time, exp_r.ok, out_ok);
            errors++;
          end
        end
      end
    end
    pending = awaited_results.size();
  end
endmodule

// ===== tb/sv/first_fit_allocator_compaction_test.sv =====
// Top of the first-fit allocator testbench: stimulus and verdict
`timescale 1ns / 100ps
module first_fit_allocator_compaction_test;
  import ffac_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 4000000;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_psel, cfg_penable, cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;
  logic              idle_on;
  int                pending, errors;
  int                alloc_sent;
  int unsigned       cycles;

  ffac_in_if  in_ch ();
  ffac_out_if out_ch ();

  first_fit_allocator_compaction dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  first_fit_allocator_compaction_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_op(in_ch.op),
    .in_alloc_size(in_ch.alloc_size), .in_handle(in_ch.handle_in),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_handle(out_ch.handle_out), .out_ok(out_ch.ok),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_pready(cfg_pready), .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .pending(pending), .errors(errors)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (idle_on && $urandom_range(0, 1)) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
  end

  task automatic send_op(logic [OP_W-1:0] op, logic [SIZE_W-1:0] sz, logic [HANDLE_W-1:0] h);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.alloc_size <= sz;
    in_ch.handle_in <= h;
    if (op == OP_ALLOC) alloc_sent++;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_mem_size(logic [SIZE_W-1:0] units);
    drain();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= '0;
    cfg_pwdata <= {$urandom} & ~32'h1FF | units;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random(int unsigned cap);
    int unsigned pick;
    logic [HANDLE_W-1:0] h;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      if ($urandom_range(0, 9) == 0) send_op(OP_ALLOC, SIZE_W'($urandom), '0);
      else send_op(OP_ALLOC, SIZE_W'($urandom_range(1, (cap > 40) ? cap / 4 : cap + 1)), $urandom);
    end else if (pick < 85) begin
      h = $urandom_range(1, alloc_sent + 1);
      if ($urandom_range(0, 9) == 0) h = $urandom;
      send_op(OP_ERASE, $urandom, h);
    end else if (pick < 96) begin
      send_op(OP_DEFRAG, $urandom, $urandom);
    end else begin
      send_op(OP_UNUSED, $urandom, $urandom);
    end
  endtask

  initial begin
    int unsigned phase_units [8] = '{256, 1, 511, 16, 64, 200, 0, 256};
    rst_n <= 1'b0;
    idle_on <= 1'b1;
    cycles <= 0;
    alloc_sent = 0;
    in_ch.valid <= 1'b0;
    in_ch.op <= OP_ALLOC;
    in_ch.alloc_size <= '0;
    in_ch.handle_in <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_op(OP_ALLOC, 9'd0, '0);
    send_op(OP_ALLOC, 9'h1FF, '0);
    send_op(OP_ALLOC, 9'd256, '0);
    send_op(OP_ALLOC, 9'd1, '0);
    send_op(OP_DEFRAG, '0, '0);
    send_op(OP_ERASE, '0, 32'd1);
    send_op(OP_ERASE, '0, 32'd1);
    send_op(OP_ERASE, '0, 32'd0);
    send_op(OP_ERASE, 9'h1FF, 32'hFFFF_FFFF);
    send_op(OP_UNUSED, 9'h1FF, 32'hFFFF_FFFF);
    send_op(OP_DEFRAG, '0, '0);
    send_op(OP_ALLOC, 9'd10, '0);
    send_op(OP_ALLOC, 9'd20, '0);
    send_op(OP_ALLOC, 9'd5, '0);
    send_op(OP_ERASE, '0, 32'd3);
    send_op(OP_ALLOC, 9'd3, '0);
    send_op(OP_ERASE, '0, 32'd2);
    send_op(OP_DEFRAG, '0, '0);
    send_op(OP_ALLOC, 9'd256, '0);
    write_mem_size(9'd8);
    send_op(OP_ALLOC, 9'd4, '0);
    write_mem_size(9'd0);
    send_op(OP_ALLOC, 9'd1, '0);
    write_mem_size(9'h1FF);
    send_op(OP_ALLOC, 9'd300, '0);
    send_op(OP_ALLOC, 9'd200, '0);

    write_mem_size(9'd256);
    for (int h = 1; h <= alloc_sent; h++) send_op(OP_ERASE, '0, h);
    repeat (260) send_op(OP_ALLOC, 9'd1, $urandom);
    repeat (20) send_random(256);

    foreach (phase_units[p]) begin
      write_mem_size(phase_units[p]);
      if (p == 7) idle_on <= 1'b0;
      repeat (100) send_random((phase_units[p] > 256) ? 256 : phase_units[p]);
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
